// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; the synthesis build sees empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define SWAM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("swam assertion failed");
// clocked check that also holds during reset
`define SWAM_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("swam assertion failed");
`else
`define SWAM_ASSERT(label, clk, rst_n, prop)
`define SWAM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/swam_pkg.sv =====
// shared types and constants for the sliding window anagram matcher
// no dependencies
package swam_pkg;

	localparam int MAX_WINDOW_DEF    = 256;
	localparam int ALPHABET_SIZE_DEF = 26;

	localparam int FUNC_W   = 2;
	localparam int LETTER_W = 5;
	localparam int ERR_W    = 2;

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd2;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
	localparam logic [ERR_W-1:0] ERR_TOO_LONG   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_AFTER_TEXT = 2'd2;

	// histogram update controls for one processed item
	typedef struct packed {
		logic                clr;
		logic                pat_inc;
		logic                txt_inc;
		logic                txt_dec;
		logic [LETTER_W-1:0] letter;
		logic [LETTER_W-1:0] old_letter;
	} hist_ctrl_t;

endpackage

// ===== hw/rtl/swam_in_if.sv =====
// input channel: valid/ready handshake with func and letter payload
// depends on swam_pkg
interface swam_in_if import swam_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [LETTER_W-1:0] letter;

	modport source (output valid, output func, output letter, input ready);
	modport sink (input valid, input func, input letter, output ready);
endinterface

// ===== hw/rtl/swam_out_if.sv =====
// result channel: valid/ready handshake with match, found and error payload
// depends on swam_pkg
interface swam_out_if import swam_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             window_match;
	logic             found;
	logic [ERR_W-1:0] error_code;

	modport source (output valid, output window_match, output found, output error_code,
		input ready);
	modport sink (input valid, input window_match, input found, input error_code,
		output ready);
endinterface

// ===== hw/rtl/sliding_window_anagram_match.sv =====
// Sliding window anagram matcher. Items of func/letter enter on the letters
// channel; each produces one result on the results channel. Pattern letters
// build a letter histogram, text letters slide a window as long as the
// pattern and report whether that window is a permutation of the pattern,
// plus a sticky found flag. One item is taken every clock cycle while the
// results channel is not stalled; each item passes through the input register,
// then the result register. The window's leaving letter comes from the history
// ring, whose registered read is issued ahead at the slot the next text letter
// needs, so the histogram lanes' increment, decrement and equality compare all
// fit between the input and result registers. No clearing pass follows reset.
// Depends on swam_pkg, swam_in_if, swam_out_if, swam_hist, swam_ring.
`include "assert_macros.svh"

module sliding_window_anagram_match import swam_pkg::*; #(
	parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	swam_in_if.sink    letters,
	swam_out_if.source results
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int SW = LW + 1;

	// input register
	logic                valid_s1;
	logic [FUNC_W-1:0]   func_s1;
	logic [LETTER_W-1:0] letter_s1;

	// result register
	logic             out_valid_q;
	logic             match_q;
	logic             found_q;
	logic [ERR_W-1:0] err_q;

	// block state
	logic [LW-1:0] plen_q;
	logic [LW-1:0] seen_q;
	logic [AW-1:0] ptr_q;
	logic          started_q;

	logic [LW-1:0] plen_d;
	logic [LW-1:0] seen_d;
	logic [AW-1:0] ptr_d;
	logic          started_d;
	logic          found_d;
	logic          match_d;
	logic [ERR_W-1:0] err_d;

	logic out_free;
	logic advance;
	logic letter_ok;
	logic is_clr;
	logic is_pat;
	logic is_txt;
	logic full_now;
	logic full_after;
	logic hist_equal;
	logic ring_we;
	logic [LETTER_W-1:0] old_letter;
	logic [LW-1:0]       ptr_inc;
	logic [SW-1:0]       rd_sum;
	logic [AW-1:0]       rd_addr;
	hist_ctrl_t          hctrl;

	// handshake: the result register frees the input register
	assign out_free      = !out_valid_q || results.ready;
	assign advance       = valid_s1 && out_free;
	assign letters.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (letters.valid && letters.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (letters.valid && letters.ready) begin
			func_s1   <= letters.func;
			letter_s1 <= letters.letter;
		end
	end

	// item decode; out-of-range pattern or text letters and the unused code change nothing
	assign letter_ok = (32'(letter_s1) < ALPHABET_SIZE);
	assign is_clr    = advance && (func_s1 == FUNC_CLEAR);
	assign is_pat    = advance && (func_s1 == FUNC_PATTERN) && letter_ok;
	assign is_txt    = advance && (func_s1 == FUNC_TEXT) && letter_ok;

	assign full_now   = (seen_q >= plen_q);
	assign full_after = full_now || (LW'(seen_q + LW'(1)) >= plen_q);
	assign ptr_inc    = LW'(ptr_q) + LW'(1);

	always_comb begin
		plen_d    = plen_q;
		seen_d    = seen_q;
		ptr_d     = ptr_q;
		started_d = started_q;
		found_d   = found_q;
		match_d   = 1'b0;
		err_d     = ERR_OK;
		hctrl     = '0;
		hctrl.letter     = letter_s1;
		hctrl.old_letter = old_letter;
		ring_we   = 1'b0;
		if (is_clr) begin
			plen_d    = '0;
			seen_d    = '0;
			ptr_d     = '0;
			started_d = 1'b0;
			found_d   = 1'b0;
			hctrl.clr = 1'b1;
		end else if (is_pat) begin
			// late pattern letter is checked before the length limit
			priority if (started_q) begin
				err_d = ERR_AFTER_TEXT;
			end else if (plen_q == LW'(MAX_WINDOW)) begin
				err_d = ERR_TOO_LONG;
			end else begin
				hctrl.pat_inc = 1'b1;
				plen_d        = plen_q + LW'(1);
			end
		end else if (is_txt) begin
			started_d = 1'b1;
			if (plen_q == '0) begin
				// empty pattern matches every text letter
				match_d = 1'b1;
			end else begin
				hctrl.txt_inc = 1'b1;
				hctrl.txt_dec = full_now;
				if (!full_now) begin
					seen_d = seen_q + LW'(1);
				end
				ring_we = 1'b1;
				ptr_d   = (ptr_inc == LW'(MAX_WINDOW)) ? '0 : AW'(ptr_inc);
				match_d = full_after && hist_equal;
			end
			if (match_d) begin
				found_d = 1'b1;
			end
		end
	end

	// prefetch slot of the letter that leaves the window on the next text letter
	always_comb begin
		rd_sum = SW'(ptr_d) + SW'(MAX_WINDOW) - SW'(plen_d);
		if (rd_sum >= SW'(MAX_WINDOW)) begin
			rd_sum = rd_sum - SW'(MAX_WINDOW);
		end
		rd_addr = AW'(rd_sum);
	end

	swam_hist #(
		.MAX_WINDOW    (MAX_WINDOW),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (hctrl),
		.equal  (hist_equal)
	);

	swam_ring #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ptr_q),
		.wdata (letter_s1),
		.raddr (rd_addr),
		.rdata (old_letter)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			seen_q    <= '0;
			ptr_q     <= '0;
			started_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			plen_q    <= plen_d;
			seen_q    <= seen_d;
			ptr_q     <= ptr_d;
			started_q <= started_d;
			found_q   <= found_d;
		end
	end

	// result register, held while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			match_q <= match_d;
			err_q   <= err_d;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.window_match = match_q;
	assign results.found        = found_q;
	assign results.error_code   = err_q;

	// window fill never passes the pattern length, which never passes the limit
	`SWAM_ASSERT_ALWAYS(a_seen_le_plen, clk, seen_q <= plen_q)
	`SWAM_ASSERT_ALWAYS(a_plen_le_max, clk, plen_q <= LW'(MAX_WINDOW))
	// an empty input register always takes a transfer
	`SWAM_ASSERT(a_ready_when_empty, clk, arst_n, !valid_s1 |-> letters.ready)
	// a text letter against an empty pattern reports a match and sets found
	`SWAM_ASSERT(a_empty_pattern_match, clk, arst_n,
		(is_txt && (plen_q == '0)) |=> (match_q && found_q && out_valid_q))

endmodule

// ===== hw/rtl/swam_ring.sv =====
// history ring of text letters, one write and one registered read per cycle
// depends on swam_pkg
module swam_ring import swam_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [LETTER_W-1:0] wdata,
	input  logic [AW-1:0]       raddr,
	output logic [LETTER_W-1:0] rdata
);

	logic [LETTER_W-1:0] mem [MAX_WINDOW];
	logic [LETTER_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-through when the same slot is written in this cycle
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/swam_hist.sv =====
// pattern and window letter histograms, one lane per letter, with equality
// depends on swam_pkg
module swam_hist import swam_pkg::*; #(
	parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
	localparam int CW = $clog2(MAX_WINDOW + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  hist_ctrl_t ctrl,
	output logic       equal
);

	logic [CW-1:0]            pc_q [ALPHABET_SIZE];
	logic [CW-1:0]            wc_q [ALPHABET_SIZE];
	logic [CW-1:0]            pc_d [ALPHABET_SIZE];
	logic [CW-1:0]            wc_d [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] eq_vec;

	for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_lane
		logic hit_new;
		logic hit_old;
		logic inc;
		logic dec;

		assign hit_new = (32'(ctrl.letter) == k);
		assign hit_old = (32'(ctrl.old_letter) == k);
		assign inc     = ctrl.txt_inc && hit_new;
		// never count below zero
		assign dec     = ctrl.txt_dec && hit_old && (wc_q[k] != '0);

		always_comb begin
			if (ctrl.clr) begin
				pc_d[k] = '0;
				wc_d[k] = '0;
			end else begin
				pc_d[k] = (ctrl.pat_inc && hit_new) ? pc_q[k] + CW'(1) : pc_q[k];
				wc_d[k] = wc_q[k] + CW'(inc) - CW'(dec);
			end
		end

		assign eq_vec[k] = (wc_d[k] == pc_q[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pc_q[k] <= '0;
				wc_q[k] <= '0;
			end else begin
				pc_q[k] <= pc_d[k];
				wc_q[k] <= wc_d[k];
			end
		end
	end

	assign equal = &eq_vec;

endmodule

// ===== sim/swam_check_pkg.sv =====
// window tracker for the sliding window anagram matcher testbench
// depends on swam_pkg for widths, function and error codes
package swam_check_pkg;
	import swam_pkg::*;

	typedef struct packed {
		logic             window_match;
		logic             found;
		logic [ERR_W-1:0] error_code;
	} verdict_t;

	class anagram_window_tracker;
		logic [8:0]          pattern_hist [ALPHABET_SIZE_DEF];
		logic [8:0]          window_hist [ALPHABET_SIZE_DEF];
		logic [LETTER_W-1:0] letter_ring [MAX_WINDOW_DEF];
		int unsigned         pattern_len;
		int unsigned         text_count;
		int unsigned         wr_slot;
		bit                  found_seen;
		bit                  text_begun;
		verdict_t            awaited_verdicts [$];
		int unsigned         mismatches;
		int unsigned         verdicts_checked;
		int unsigned         matches_seen;
		int unsigned         errors_seen;

		function new();
			restart();
			mismatches       = 0;
			verdicts_checked = 0;
			matches_seen     = 0;
			errors_seen      = 0;
		endfunction

		function void restart();
			foreach (pattern_hist[k]) pattern_hist[k] = '0;
			foreach (window_hist[k]) window_hist[k] = '0;
			foreach (letter_ring[k]) letter_ring[k] = '0;
			pattern_len = 0;
			text_count  = 0;
			wr_slot     = 0;
			found_seen  = 1'b0;
			text_begun  = 1'b0;
		endfunction

		// work out the verdict that one accepted letter transfer will cause
		function void take_letter(logic [FUNC_W-1:0] func_code, logic [LETTER_W-1:0] letter_idx);
			verdict_t            v;
			int unsigned         pos;
			logic [LETTER_W-1:0] leaving;
			bit                  in_range;
			bit                  same;
			v        = '0;
			in_range = (letter_idx < ALPHABET_SIZE_DEF);
			if (func_code == FUNC_CLEAR) begin
				restart();
			end else if (func_code == FUNC_PATTERN && in_range) begin
				if (text_begun) begin
					v.error_code = ERR_AFTER_TEXT;
				end else if (pattern_len >= MAX_WINDOW_DEF) begin
					v.error_code = ERR_TOO_LONG;
				end else begin
					pattern_hist[letter_idx]++;
					pattern_len++;
				end
			end else if (func_code == FUNC_TEXT && in_range) begin
				text_begun = 1'b1;
				if (pattern_len == 0) begin
					v.window_match = 1'b1;
				end else begin
					if (text_count >= pattern_len) begin
						pos     = (wr_slot + MAX_WINDOW_DEF - pattern_len) % MAX_WINDOW_DEF;
						leaving = letter_ring[pos];
						if (leaving < ALPHABET_SIZE_DEF && window_hist[leaving] != 0)
							window_hist[leaving]--;
					end else begin
						text_count++;
					end
					window_hist[letter_idx]++;
					letter_ring[wr_slot] = letter_idx;
					wr_slot = (wr_slot + 1 >= MAX_WINDOW_DEF) ? 0 : wr_slot + 1;
					if (text_count >= pattern_len) begin
						same = 1'b1;
						for (int k = 0; k < ALPHABET_SIZE_DEF; k++)
							if (pattern_hist[k] != window_hist[k]) same = 1'b0;
						v.window_match = same;
					end
				end
				if (v.window_match) found_seen = 1'b1;
			end
			v.found = found_seen;
			awaited_verdicts.push_back(v);
		endfunction

		function void check_verdict(logic match_bit, logic found_bit, logic [ERR_W-1:0] err);
			verdict_t exp_v;
			if (awaited_verdicts.size() == 0) begin
				$error("result transfer with no verdict awaited");
				mismatches++;
				return;
			end
			exp_v = awaited_verdicts.pop_front();
			verdicts_checked++;
			if (exp_v.window_match) matches_seen++;
			if (exp_v.error_code != ERR_OK) errors_seen++;
			if (match_bit !== exp_v.window_match) begin
				$error("window_match: expected %0d, actual %0d", exp_v.window_match, match_bit);
				mismatches++;
			end
			if (found_bit !== exp_v.found) begin
				$error("found: expected %0d, actual %0d", exp_v.found, found_bit);
				mismatches++;
			end
			if (err !== exp_v.error_code) begin
				$error("error_code: expected %0d, actual %0d", exp_v.error_code, err);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return awaited_verdicts.size();
		endfunction
	endclass

endpackage

// ===== sim/sliding_window_anagram_match_test.sv =====
// testbench top for the sliding window anagram matcher: directed and random
// letter streams, random stalls on both channels, verdicts checked in order
// depends on swam_pkg, swam_in_if, swam_out_if, swam_check_pkg and the block
module sliding_window_anagram_match_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swam_pkg::*;
	import swam_check_pkg::*;

	// func value the block has no meaning for
	localparam logic [FUNC_W-1:0]   FUNC_UNUSED  = 2'd3;
	localparam logic [LETTER_W-1:0] LETTER_TOP   = '1;
	localparam int                  RANDOM_ITEMS = 1250;
	localparam int                  QUIET_TAIL   = 150;
	localparam int                  SETTLE_CYCLES = 10;
	localparam int unsigned         CYCLE_LIMIT  = 400000;

	logic clk = 1'b0;
	logic arst_n;

	swam_in_if  letters_ch ();
	swam_out_if results_ch ();

	sliding_window_anagram_match u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.letters (letters_ch),
		.results (results_ch)
	);

	anagram_window_tracker tracker = new();

	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	// no idling on either side once set
	bit quiet = 1'b0;

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// every accepted result goes against the oldest verdict waiting
	always @(posedge clk) begin
		if (arst_n === 1'b1 && results_ch.valid && results_ch.ready)
			tracker.check_verdict(results_ch.window_match, results_ch.found,
				results_ch.error_code);
	end

	// result side: ready drops in random bursts, mostly stays high
	initial begin
		results_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				results_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
		end
	end

	// one letter transfer, sometimes with a random gap ahead of it; valid stays high
	// into the next call so back-to-back transfers run without a gap
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [LETTER_W-1:0] l);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			letters_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		letters_ch.valid  <= 1'b1;
		letters_ch.func   <= f;
		letters_ch.letter <= l;
		@(posedge clk);
		while (!letters_ch.ready) @(posedge clk);
		tracker.take_letter(f, l);
		items_sent++;
		if (items_sent > RANDOM_ITEMS + 25 - QUIET_TAIL) quiet = 1'b1;
	endtask

	// hold the sender off until every verdict has come back
	task automatic drain();
		letters_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// short pattern, text made of shuffled pattern copies, local letters and noise
	task automatic run_typical();
		logic [LETTER_W-1:0] pat_q [$];
		logic [LETTER_W-1:0] perm [$];
		logic [LETTER_W-1:0] tmp;
		int unsigned plen, tlen, span, base, n, choice, j;
		if ($urandom_range(0, 4) != 0)
			send_item(FUNC_CLEAR, LETTER_W'($urandom_range(0, LETTER_TOP)));
		plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
		span = ($urandom_range(0, 3) == 0) ? ALPHABET_SIZE_DEF : $urandom_range(2, 4);
		base = $urandom_range(0, ALPHABET_SIZE_DEF - span);
		for (int i = 0; i < plen; i++) begin
			pat_q.push_back(LETTER_W'(base + $urandom_range(0, span - 1)));
			send_item(FUNC_PATTERN, pat_q[i]);
		end
		tlen = $urandom_range(4, 30);
		n = 0;
		while (n < tlen) begin
			choice = $urandom_range(0, 9);
			if (choice < 4 && plen > 0) begin
				// a permutation of the pattern, so some window will match
				perm = pat_q;
				for (int i = perm.size() - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				foreach (perm[i]) send_item(FUNC_TEXT, perm[i]);
				n += perm.size();
			end else if (choice < 9) begin
				send_item(FUNC_TEXT, LETTER_W'(base + $urandom_range(0, span - 1)));
				n++;
			end else begin
				// noise: any func, any letter, out of range included
				send_item(FUNC_W'($urandom_range(0, 3)),
					LETTER_W'($urandom_range(0, LETTER_TOP)));
				n++;
			end
		end
		// late pattern letter, rejected once text has begun
		if ($urandom_range(0, 3) == 0)
			send_item(FUNC_PATTERN, LETTER_W'($urandom_range(0, 25)));
	endtask

	// pattern past the window limit, text long enough to fill and wrap the ring
	task automatic run_long_pattern();
		logic [LETTER_W-1:0] pat_q [$];
		int unsigned extra;
		send_item(FUNC_CLEAR, '0);
		extra = $urandom_range(1, 4);
		for (int i = 0; i < MAX_WINDOW_DEF + extra; i++) begin
			pat_q.push_back(LETTER_W'($urandom_range(0, 1)));
			send_item(FUNC_PATTERN, pat_q[i]);
		end
		// text repeats the kept pattern, so the first full window matches
		for (int i = 0; i < MAX_WINDOW_DEF; i++) begin
			if (i == 100) send_item(FUNC_PATTERN, '0);
			send_item(FUNC_TEXT, pat_q[i]);
		end
		repeat (20) send_item(FUNC_TEXT, LETTER_W'($urandom_range(0, 1)));
	endtask

	// short pattern over a text longer than the ring
	task automatic run_ring_wrap();
		send_item(FUNC_CLEAR, '0);
		repeat (3) send_item(FUNC_PATTERN, LETTER_W'($urandom_range(5, 7)));
		repeat (300) send_item(FUNC_TEXT, LETTER_W'($urandom_range(5, 7)));
	endtask

	initial begin
		int unsigned scenario;
		arst_n            <= 1'b0;
		letters_ch.valid  <= 1'b0;
		letters_ch.func   <= FUNC_CLEAR;
		letters_ch.letter <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pattern matches at once
		send_item(FUNC_TEXT, 5'd0);
		send_item(FUNC_TEXT, 5'd25);
		send_item(FUNC_CLEAR, LETTER_TOP);
		// pattern a z b, with out of range and unused items mixed in
		send_item(FUNC_PATTERN, 5'd0);
		send_item(FUNC_PATTERN, 5'd25);
		send_item(FUNC_PATTERN, 5'd26);
		send_item(FUNC_PATTERN, 5'd1);
		send_item(FUNC_UNUSED, 5'd0);
		send_item(FUNC_TEXT, LETTER_TOP);
		// partial windows, then a full one that matches
		send_item(FUNC_TEXT, 5'd25);
		send_item(FUNC_TEXT, 5'd0);
		send_item(FUNC_TEXT, 5'd1);
		// pattern letter after text began
		send_item(FUNC_PATTERN, 5'd16);
		send_item(FUNC_TEXT, 5'd2);
		send_item(FUNC_TEXT, 5'd25);
		send_item(FUNC_TEXT, 5'd0);
		send_item(FUNC_UNUSED, LETTER_TOP);
		send_item(FUNC_TEXT, 5'd1);
		send_item(FUNC_CLEAR, 5'd16);
		send_item(FUNC_PATTERN, LETTER_TOP);
		send_item(FUNC_TEXT, 5'd16);
		send_item(FUNC_CLEAR, 5'd0);

		// random part
		scenario = 0;
		while (items_sent < RANDOM_ITEMS + 25) begin
			if (scenario == 2) begin
				run_long_pattern();
				drain();
			end else if (scenario == 5) begin
				run_ring_wrap();
			end else begin
				run_typical();
			end
			scenario++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d letter transfers in %0d cycles: %0d verdicts, %0d window matches",
			items_sent, cycle_count, tracker.verdicts_checked, tracker.matches_seen);
		$display("error codes reported: %0d", tracker.errors_seen);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
